### src/tle_pkg.sv
`default_nettype none

package tle_pkg;

    localparam int DEPTH_DEF = 32;   // default line capacity
    localparam int SLOTS     = 32;   // ring slots, indexed by count mod SLOTS
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = 6;    // write and read counts wrap mod 64
    localparam int BYTE_W    = 8;

    localparam logic [BYTE_W-1:0] CH_BS       = 8'd8;
    localparam logic [BYTE_W-1:0] CH_LF       = 8'd10;
    localparam logic [BYTE_W-1:0] CH_CR       = 8'd13;
    localparam logic [BYTE_W-1:0] CH_ESC      = 8'd27;
    localparam logic [BYTE_W-1:0] CH_SPACE    = 8'd32;
    localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'd91;
    localparam logic [BYTE_W-1:0] CH_P        = 8'd80;

    localparam logic ACT_RECEIVE = 1'b0;
    localparam logic ACT_DRAIN   = 1'b1;

    // echo sequence kinds
    typedef enum logic [1:0] {
        E_BS     = 2'd0,
        E_BYTE   = 2'd1,
        E_SILENT = 2'd2
    } t_echo;

    // output word source
    typedef enum logic [1:0] {
        OS_SEQ  = 2'd0,
        OS_HOLD = 2'd1,
        OS_CR   = 2'd2
    } t_out_sel;

    typedef struct packed {
        logic     capture;
        logic     store;
        logic     wr_dec;
        logic     arm;
        logic     rd_issue;
        logic     out_load;
        t_out_sel out_sel;
        t_echo    kind;
        logic [1:0] idx;
        logic     out_last;
        logic     out_chunk;
        logic     hold_lf;
        logic     hold_rd;
    } t_cmd;

    typedef struct packed {
        logic action;
        logic is_bs;
        logic is_print;
        logic is_cr;
        logic chunk_last;
        logic occ_zero;
        logic has_room;
        logic rd_is_cr;
        logic out_free;
    } t_sts;

    // erase-character echo: BS, ESC, '[', 'P'
    function automatic logic [BYTE_W-1:0] bs_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] b;
        unique case (idx)
            2'd0: b = CH_BS;
            2'd1: b = CH_ESC;
            2'd2: b = CH_LBRACKET;
            2'd3: b = CH_P;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### src/tle_ram.sv
`default_nettype none

module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/tle_ctrl.sv
`default_nettype none

module tle_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire tle_pkg::t_sts i_sts,
    output tle_pkg::t_cmd      o_cmd,
    output logic               o_in_ready
);

    import tle_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_ECHO   = 7'b0000100,
        S_DCR    = 7'b0001000,
        S_DRD    = 7'b0010000,
        S_DWAIT  = 7'b0100000,
        S_DFIN   = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    t_echo      r_kind,  n_kind;
    logic [1:0] r_idx,   n_idx;
    logic       seq_final;

    assign seq_final = (r_kind != E_BS) || (r_idx == 2'd3);

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_idx   = r_idx;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_idx   = 2'd0;
                n_state = S_IDLE;
                if (i_sts.action == ACT_DRAIN) begin
                    n_state = S_DCR;
                end else if (i_sts.is_bs && !i_sts.occ_zero) begin
                    o_cmd.wr_dec = 1'b1;
                    n_kind       = E_BS;
                    n_state      = S_ECHO;
                end else if (i_sts.is_print && !i_sts.is_cr) begin
                    o_cmd.store = i_sts.has_room;
                    n_kind      = E_BYTE;
                    n_state     = S_ECHO;
                end else begin
                    // a carriage return, stored if room, arms the flag but echoes nothing
                    if (i_sts.is_cr) begin
                        o_cmd.store = i_sts.has_room;
                        o_cmd.arm   = 1'b1;
                    end
                    if (i_sts.chunk_last) begin
                        n_kind  = E_SILENT;
                        n_state = S_ECHO;
                    end
                end
            end
            S_ECHO: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_sel   = OS_SEQ;
                    o_cmd.kind      = r_kind;
                    o_cmd.idx       = r_idx;
                    o_cmd.out_last  = seq_final;
                    o_cmd.out_chunk = seq_final && i_sts.chunk_last;
                    if (seq_final) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
            end
            S_DCR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OS_CR;
                    o_cmd.hold_lf  = 1'b1;
                    n_state        = S_DRD;
                end
            end
            S_DRD: begin
                if (i_sts.occ_zero) begin
                    n_state = S_DFIN;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_DWAIT;
                end
            end
            S_DWAIT: begin
                // skip stored carriage returns; otherwise push the held word out
                if (i_sts.rd_is_cr) begin
                    n_state = S_DRD;
                end else if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OS_HOLD;
                    o_cmd.hold_rd  = 1'b1;
                    n_state        = S_DRD;
                end
            end
            S_DFIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OS_HOLD;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= E_BS;
            r_idx   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_idx   <= n_idx;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

### src/tle_dp.sv
`default_nettype none

module tle_dp #(
    parameter int DEPTH = tle_pkg::DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire tle_pkg::t_cmd              i_cmd,
    input  wire logic                       i_action,
    input  wire logic [tle_pkg::BYTE_W-1:0] i_rx_byte,
    input  wire logic                       i_chunk_last,
    input  wire logic                       i_out_ready,
    output tle_pkg::t_sts                   o_sts,
    output logic                            o_out_valid,
    output logic [tle_pkg::BYTE_W-1:0]      o_tx_byte,
    output logic                            o_tx_valid,
    output logic                            o_line_ready,
    output logic                            o_last
);

    import tle_pkg::*;

    logic              r_action;
    logic [BYTE_W-1:0] r_byte;
    logic              r_chunk;
    logic [CNT_W-1:0]  r_wr, n_wr;
    logic [CNT_W-1:0]  r_rd;
    logic              r_enter;
    logic [BYTE_W-1:0] r_hold;
    logic              r_o_valid;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_txv;
    logic              r_o_line;
    logic              r_o_last;

    logic [CNT_W-1:0]  occ;
    logic [BYTE_W-1:0] rdata;
    logic [BYTE_W-1:0] sel_byte;
    logic              sel_txv;
    logic              out_free;

    assign occ      = r_wr - r_rd;
    assign out_free = !r_o_valid || i_out_ready;

    tle_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (r_wr[SLOT_W-1:0]),
        .i_wdata (r_byte),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_rd[SLOT_W-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        sel_byte = '0;
        sel_txv  = 1'b1;
        unique case (i_cmd.out_sel)
            OS_SEQ: begin
                unique case (i_cmd.kind)
                    E_BS:     sel_byte = bs_byte(i_cmd.idx);
                    E_BYTE:   sel_byte = r_byte;
                    E_SILENT: sel_txv  = 1'b0;
                    default:  sel_txv  = 1'b0;
                endcase
            end
            OS_HOLD: sel_byte = r_hold;
            OS_CR:   sel_byte = CH_CR;
            default: sel_byte = '0;
        endcase
    end

    always_comb begin
        n_wr = r_wr;
        if (i_cmd.store) begin
            n_wr = r_wr + CNT_W'(1);
        end else if (i_cmd.wr_dec) begin
            n_wr = r_wr - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr      <= '0;
            r_rd      <= '0;
            r_enter   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_wr <= n_wr;
            if (i_cmd.rd_issue) begin
                r_rd <= r_rd + CNT_W'(1);
            end
            if (i_cmd.arm) begin
                r_enter <= 1'b1;
            end else if (i_cmd.out_load && i_cmd.out_chunk) begin
                r_enter <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_byte   <= i_rx_byte;
            r_chunk  <= i_chunk_last;
        end
        if (i_cmd.hold_lf) begin
            r_hold <= CH_LF;
        end else if (i_cmd.hold_rd) begin
            r_hold <= rdata;
        end
        if (i_cmd.out_load) begin
            r_o_byte <= sel_byte;
            r_o_txv  <= sel_txv;
            r_o_line <= i_cmd.out_chunk && r_enter;
            r_o_last <= i_cmd.out_last;
        end
    end

    always_comb begin
        o_sts.action     = r_action;
        o_sts.is_bs      = (r_byte == CH_BS);
        o_sts.is_print   = (r_byte >= CH_SPACE) || (r_byte == CH_CR);
        o_sts.is_cr      = (r_byte == CH_CR);
        o_sts.chunk_last = r_chunk;
        o_sts.occ_zero   = (occ == '0);
        o_sts.has_room   = (occ < CNT_W'(DEPTH));
        o_sts.rd_is_cr   = (rdata == CH_CR);
        o_sts.out_free   = out_free;
    end

    assign o_out_valid  = r_o_valid;
    assign o_tx_byte    = r_o_byte;
    assign o_tx_valid   = r_o_txv;
    assign o_line_ready = r_o_line;
    assign o_last       = r_o_last;

endmodule

`default_nettype wire

### src/terminal_line_editor_fifo.sv
// Console line editor over a ring buffer of received bytes.
// Slave channel carries one item per word: tdata = received byte, tuser = action
// (0 receive, 1 drain), tlast = final byte of a received burst. Master channel
// carries echo words: tdata = byte to send, tuser[0] = byte valid,
// tuser[1] = line ready, tlast = final word of the item.
// One item is worked at a time; s_axis_tready is high only while the controller
// is idle. A receive item passes a decode state and then sends its echo words
// (a backspace on a non-empty line gives four words, a printable byte one, a
// chunk end with nothing to echo one word with tuser[0] low); the first word is
// loaded into the output register from the echo state. A drain sends CR, then LF
// and the stored bytes through a one-word hold register so the final word can
// carry tlast; each stored byte is fetched by a registered read of the buffer
// RAM, in a read state and then a wait state.
// Reset empties the line and clears the enter flag; buffer contents are not
// cleared and no clearing pass runs. When the receiver stalls the output word
// holds and the controller waits, so no word is lost.
`default_nettype none

module terminal_line_editor_fifo #(
    parameter int DEPTH = tle_pkg::DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [0:0] s_axis_tuser,   // [0] action
    input  wire logic       s_axis_tlast,   // chunk_last
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] tx_byte
    output logic [1:0]      m_axis_tuser,   // [0] tx_valid, [1] line_ready
    output logic            m_axis_tlast    // last
);

    import tle_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic tx_valid;
    logic line_ready;

    tle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (s_axis_tready)
    );

    tle_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_action     (s_axis_tuser[0]),
        .i_rx_byte    (s_axis_tdata),
        .i_chunk_last (s_axis_tlast),
        .i_out_ready  (m_axis_tready),
        .o_sts        (sts),
        .o_out_valid  (m_axis_tvalid),
        .o_tx_byte    (m_axis_tdata),
        .o_tx_valid   (tx_valid),
        .o_line_ready (line_ready),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tuser = {line_ready, tx_valid};

endmodule

`default_nettype wire
